// ===== hw/rtl/apr_pkg.sv =====
package apr_pkg;

   localparam int MAX_WIDTH     = 2048;
   localparam int MAX_CHANNELS  = 4;
   localparam int MAX_HEIGHT    = 65535;
   localparam int STORE_DEPTH   = MAX_WIDTH * MAX_CHANNELS;
   localparam int ADDR_BITS     = $clog2(STORE_DEPTH);
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int CH_BITS       = $clog2(MAX_CHANNELS);
   localparam int ROW_BITS      = 16;
   localparam int WIDTH_BITS    = 12;
   localparam int HEIGHT_BITS   = 16;
   localparam int BPP_BITS      = 3;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_BPP    = 2'd2;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  width;
      logic [HEIGHT_BITS-1:0] height;
      logic [BPP_BITS-1:0]    bpp;
   } limits_type;

endpackage

// ===== hw/rtl/apr_channels.sv =====
interface apr_req_if;
   logic               valid;
   logic               ready;
   apr_pkg::byte_type  residual;

   modport source (output valid, output residual, input ready);
   modport sink   (input valid, input residual, output ready);
endinterface

interface apr_rsp_if;
   logic               valid;
   logic               ready;
   apr_pkg::byte_type  pixel_byte;
   logic               frame_last;

   modport source (output valid, output pixel_byte, output frame_last, input ready);
   modport sink   (input valid, input pixel_byte, input frame_last, output ready);
endinterface

// ===== hw/rtl/apr_csr.sv =====
module apr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [apr_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [apr_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [apr_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready,
   output apr_pkg::limits_type                 limits
);
   import apr_pkg::*;

   logic [WIDTH_BITS-1:0]  width_ff,  width_in;
   logic [HEIGHT_BITS-1:0] height_ff, height_in;
   logic [BPP_BITS-1:0]    bpp_ff,    bpp_in;
   logic                   wr_en;
   logic [1:0]             reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      bpp_in    = bpp_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_WIDTH:  width_in  = pwdata[WIDTH_BITS-1:0];
            REG_HEIGHT: height_in = pwdata[HEIGHT_BITS-1:0];
            REG_BPP:    bpp_in    = pwdata[BPP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_BITS'(1);
         height_ff <= HEIGHT_BITS'(1);
         bpp_ff    <= BPP_BITS'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         bpp_ff    <= bpp_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_WIDTH:  prdata = CSR_DATA_BITS'(width_ff);
         REG_HEIGHT: prdata = CSR_DATA_BITS'(height_ff);
         REG_BPP:    prdata = CSR_DATA_BITS'(bpp_ff);
         default:    prdata = '0;
      endcase
   end

   // zero reads as one, oversize saturates
   always_comb begin
      if (width_ff == '0)
         limits.width = WIDTH_BITS'(1);
      else if (width_ff > WIDTH_BITS'(MAX_WIDTH))
         limits.width = WIDTH_BITS'(MAX_WIDTH);
      else
         limits.width = width_ff;

      if (height_ff == '0)
         limits.height = HEIGHT_BITS'(1);
      else
         limits.height = height_ff;

      if (bpp_ff == '0)
         limits.bpp = BPP_BITS'(1);
      else if (bpp_ff > BPP_BITS'(MAX_CHANNELS))
         limits.bpp = BPP_BITS'(MAX_CHANNELS);
      else
         limits.bpp = bpp_ff;
   end

endmodule

// ===== hw/rtl/average_predictor_reconstruct_unit.sv =====
// channel   dir  beat                          handshake
// req_bus   in   residual[7:0]                 valid/ready
// rsp_bus   out  pixel_byte[7:0], frame_last   valid/ready
// csr (APB) in   width, height, bytes/pixel    psel/penable, pready tied high
//
// One byte per clock while rsp is ready; compute stage and output are registered.
// Line store read is issued at accept, result written back as compute advances;
// same-entry back-to-back (one byte per row) goes through a bypass register.
// Synchronous reset; line store is not cleared.
// A held rsp beat stalls the compute stage, which then drops req ready.
module average_predictor_reconstruct_unit (
   input  logic                                clock,
   input  logic                                reset,
   apr_req_if.sink                             req_bus,
   apr_rsp_if.source                           rsp_bus,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [apr_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [apr_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [apr_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);
   import apr_pkg::*;

   localparam logic [1:0] PRED_ZERO  = 2'd0;
   localparam logic [1:0] PRED_LEFT  = 2'd1;
   localparam logic [1:0] PRED_ABOVE = 2'd2;
   localparam logic [1:0] PRED_AVG   = 2'd3;

   limits_type limits;

   apr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .limits  (limits)
   );

   logic [CH_BITS-1:0]   ch_ff,  ch_in;
   logic [COL_BITS-1:0]  col_ff, col_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;

   logic                 s1_valid_ff;
   byte_type             s1_residual_ff;
   logic [1:0]           s1_mode_ff;
   logic [CH_BITS-1:0]   s1_ch_ff;
   logic [ADDR_BITS-1:0] s1_idx_ff;
   logic                 s1_last_ff;
   logic                 s1_fwd_ff;
   byte_type             s1_fwd_data_ff;

   logic                 rsp_valid_ff;
   byte_type             rsp_byte_ff;
   logic                 rsp_last_ff;

   byte_type             line_mem [STORE_DEPTH];
   byte_type             rd_data_ff;
   byte_type             left_ff [MAX_CHANNELS];

   logic                 req_fire;
   logic                 s1_adv;
   logic                 ch_end, col_end, row_end, last_now;
   logic [ADDR_BITS-1:0] idx_now;
   logic [1:0]           mode_now;
   byte_type             above, left, pred, result;
   logic [8:0]           sum;

   assign s1_adv        = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign ch_end   = ({1'b0, ch_ff} + (CH_BITS+1)'(1)) >= (CH_BITS+1)'(limits.bpp);
   assign col_end  = ({1'b0, col_ff} + (COL_BITS+1)'(1)) >= (COL_BITS+1)'(limits.width);
   assign row_end  = ({1'b0, row_ff} + (ROW_BITS+1)'(1)) >= {1'b0, limits.height};
   assign last_now = ch_end && col_end && row_end;
   assign idx_now  = ADDR_BITS'({col_ff, ch_ff});

   always_comb begin
      if (row_ff == '0 && col_ff == '0)
         mode_now = PRED_ZERO;
      else if (row_ff == '0)
         mode_now = PRED_LEFT;
      else if (col_ff == '0)
         mode_now = PRED_ABOVE;
      else
         mode_now = PRED_AVG;
   end

   always_comb begin
      ch_in  = ch_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (!ch_end) begin
            ch_in = ch_ff + CH_BITS'(1);
         end else begin
            ch_in = '0;
            if (!col_end) begin
               col_in = col_ff + COL_BITS'(1);
            end else begin
               col_in = '0;
               if (!row_end)
                  row_in = row_ff + ROW_BITS'(1);
               else
                  row_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff  <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         ch_ff  <= ch_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // compute stage
   assign above  = s1_fwd_ff ? s1_fwd_data_ff : rd_data_ff;
   assign left   = left_ff[s1_ch_ff];
   assign sum    = {1'b0, left} + {1'b0, above};

   always_comb begin
      case (s1_mode_ff)
         PRED_ZERO:  pred = '0;
         PRED_LEFT:  pred = left;
         PRED_ABOVE: pred = above;
         PRED_AVG:   pred = sum[8:1];
         default:    pred = '0;
      endcase
   end

   assign result = s1_residual_ff + pred;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_residual_ff <= req_bus.residual;
         s1_mode_ff     <= mode_now;
         s1_ch_ff       <= ch_ff;
         s1_idx_ff      <= idx_now;
         s1_last_ff     <= last_now;
         s1_fwd_ff      <= s1_adv && (s1_idx_ff == idx_now);
         s1_fwd_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff <= line_mem[idx_now];
      end
      if (s1_adv) begin
         line_mem[s1_idx_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            left_ff[i] <= '0;
         end
      end else if (s1_adv) begin
         left_ff[s1_ch_ff] <= result;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_byte_ff <= result;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.pixel_byte = rsp_byte_ff;
   assign rsp_bus.frame_last = rsp_last_ff;

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted beat missing from compute stage");

   a_stage_fills_output: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("computed beat missing from output register");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      req_fire && last_now |=> (ch_ff == '0 && col_ff == '0 && row_ff == '0))
      else $error("position counters did not wrap after last beat of frame");

   a_bypass_same_entry: assert property (@(posedge clock) disable iff (reset)
      req_fire && s1_valid_ff |=> (s1_fwd_ff == ($past(s1_idx_ff) == s1_idx_ff)))
      else $error("line store bypass mismatch");

endmodule
